// ===== rtl/core/rtmf_pkg.sv =====
// Shared types, constants and codes for the response time median filter.
package rtmf_pkg;

    localparam int WINDOW_DEF = 8;

    localparam int OP_W = 2;
    localparam int TS_W = 48;
    localparam int CNT_W16 = 16;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 48;

    localparam logic [CNT_W16-1:0] COUNT_MAX = 16'hFFFF;
    localparam logic [CNT_W16-1:0] SYNC_MEDIANS_RST = 16'd1;

    typedef enum logic [OP_W-1:0] {
        OP_START      = 2'd0,
        OP_END        = 2'd1,
        OP_SYNC       = 2'd2,
        OP_SOFT_RESET = 2'd3
    } op_t;

    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_FIRST = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_PERIOD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_MEDIANS = 2'd2;

    typedef struct packed {
        logic latch_in;
        logic exec;
        logic cand_read;
        logic cand_capture;
        logic scan_step;
        logic judge;
        logic push;
    } rtmf_cmd_t;

    typedef struct packed {
        logic sort_needed;
        logic scan_last;
        logic found;
        logic cand_last;
        logic out_free;
    } rtmf_status_t;

endpackage

// ===== rtl/core/rtmf_ctrl.sv =====
// Controller state machine that sequences request execution and the median search.
module rtmf_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  rtmf_pkg::rtmf_status_t status,
    output rtmf_pkg::rtmf_cmd_t    cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_EXEC  = 8'b0000_0010,
        S_CAND  = 8'b0000_0100,
        S_CAPT  = 8'b0000_1000,
        S_SCAN  = 8'b0001_0000,
        S_DRAIN = 8'b0010_0000,
        S_JUDGE = 8'b0100_0000,
        S_PUSH  = 8'b1000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                state_next = status.sort_needed ? S_CAND : S_PUSH;
            end
            S_CAND:
            begin
                cmd.cand_read = 1'b1;
                state_next = S_CAPT;
            end
            S_CAPT:
            begin
                cmd.cand_capture = 1'b1;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_JUDGE;
            end
            S_JUDGE:
            begin
                cmd.judge = 1'b1;
                state_next = (status.found || status.cand_last) ? S_PUSH : S_CAND;
            end
            S_PUSH:
            begin
                if (status.out_free)
                begin
                    cmd.push = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != S_IDLE);

endmodule

// ===== rtl/core/rtmf_dp.sv =====
// Datapath with event state, sample window memory, rank counters and output register.
module rtmf_dp #(
    parameter int WINDOW = rtmf_pkg::WINDOW_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [rtmf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rtmf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic [rtmf_pkg::OP_W-1:0]         op,
    input  logic [rtmf_pkg::TS_W-1:0]         timestamp,
    input  logic                              out_stall,
    output logic                              out_valid,
    output logic                              median_valid,
    output logic [rtmf_pkg::TS_W-1:0]         median_time,
    output logic [rtmf_pkg::CNT_W16-1:0]      median_count,
    output logic                              has_median,
    output logic                              sync_reached,
    input  rtmf_pkg::rtmf_cmd_t               cmd,
    output rtmf_pkg::rtmf_status_t            status
);

    localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int CNT_W = $clog2(WINDOW + 1);
    localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW - 1);
    localparam logic [CNT_W-1:0] MED_RANK = CNT_W'(WINDOW / 2);

    // Registers with reset.
    logic [rtmf_pkg::CNT_W16-1:0] ignore_left_reg, ignore_left_next;
    logic                         start_pending_reg, start_pending_next;
    logic [IDX_W-1:0]             fill_reg, fill_next;
    logic [rtmf_pkg::CNT_W16-1:0] medians_done_reg, medians_done_next;
    logic [rtmf_pkg::TS_W-1:0]    sync_deadline_reg, sync_deadline_next;
    logic [rtmf_pkg::TS_W-1:0]    sync_period_reg, sync_period_next;
    logic [rtmf_pkg::CNT_W16-1:0] sync_medians_reg, sync_medians_next;
    logic                         out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]             cand_idx_reg, cand_idx_next;
    logic [IDX_W-1:0]             scan_idx_reg, scan_idx_next;
    logic                         cmp_pend_reg, cmp_pend_next;
    logic [CNT_W-1:0]             lt_cnt_reg, lt_cnt_next;
    logic [CNT_W-1:0]             le_cnt_reg, le_cnt_next;

    // Payload registers.
    rtmf_pkg::op_t                in_op_reg;
    logic [rtmf_pkg::TS_W-1:0]    in_ts_reg;
    logic [rtmf_pkg::TS_W-1:0]    start_time_reg;
    logic [rtmf_pkg::TS_W-1:0]    cand_reg;
    logic [rtmf_pkg::TS_W-1:0]    rd_data_reg;
    logic                         res_mvalid_reg;
    logic [rtmf_pkg::TS_W-1:0]    res_mtime_reg;
    logic                         res_sync_reg;
    logic                         out_mvalid_reg;
    logic [rtmf_pkg::TS_W-1:0]    out_mtime_reg;
    logic [rtmf_pkg::CNT_W16-1:0] out_count_reg;
    logic                         out_has_reg;
    logic                         out_sync_reg;

    logic [rtmf_pkg::TS_W-1:0]    window_mem [WINDOW];

    logic [rtmf_pkg::TS_W-1:0]    elapsed;
    logic [rtmf_pkg::TS_W-1:0]    deadline_sum;
    logic                         sync_hit;
    logic                         end_taken;
    logic                         window_full;
    logic [IDX_W-1:0]             rd_addr;
    logic                         smp_lt;
    logic                         smp_le;
    logic                         found;

    assign elapsed = in_ts_reg - start_time_reg;
    assign deadline_sum = in_ts_reg + sync_period_reg;
    assign sync_hit = (sync_deadline_reg < in_ts_reg) || (medians_done_reg >= sync_medians_reg);
    assign end_taken = (in_op_reg == rtmf_pkg::OP_END) && start_pending_reg;
    assign window_full = (fill_reg == IDX_LAST);
    assign rd_addr = cmd.cand_read ? cand_idx_reg : scan_idx_reg;
    assign smp_lt = (rd_data_reg < cand_reg);
    assign smp_le = (rd_data_reg <= cand_reg);
    assign found = (lt_cnt_reg <= MED_RANK) && (MED_RANK < le_cnt_reg);

    always_comb
    begin
        status.sort_needed = end_taken && window_full;
        status.scan_last = (scan_idx_reg == IDX_LAST);
        status.found = found;
        status.cand_last = (cand_idx_reg == IDX_LAST);
        status.out_free = !out_valid_reg || !out_stall;
    end

    always_comb
    begin
        ignore_left_next = ignore_left_reg;
        start_pending_next = start_pending_reg;
        fill_next = fill_reg;
        medians_done_next = medians_done_reg;
        sync_deadline_next = sync_deadline_reg;
        sync_period_next = sync_period_reg;
        sync_medians_next = sync_medians_reg;
        cand_idx_next = cand_idx_reg;
        scan_idx_next = scan_idx_reg;
        cmp_pend_next = cmd.scan_step;
        lt_cnt_next = lt_cnt_reg;
        le_cnt_next = le_cnt_reg;

        if (cfg_wr_en)
        begin
            priority if (cfg_index == rtmf_pkg::CFG_IGNORE_FIRST)
            begin
                ignore_left_next = cfg_data[rtmf_pkg::CNT_W16-1:0];
            end
            else if (cfg_index == rtmf_pkg::CFG_SYNC_PERIOD)
            begin
                sync_period_next = cfg_data;
                sync_deadline_next = cfg_data;
            end
            else if (cfg_index == rtmf_pkg::CFG_SYNC_MEDIANS)
            begin
                sync_medians_next = cfg_data[rtmf_pkg::CNT_W16-1:0];
            end
            else
            begin
                sync_medians_next = sync_medians_reg;
            end
        end

        if (cmd.exec)
        begin
            cand_idx_next = '0;
            unique case (in_op_reg)
                rtmf_pkg::OP_START:
                begin
                    if (ignore_left_reg != '0)
                    begin
                        ignore_left_next = ignore_left_reg - 16'd1;
                    end
                    else
                    begin
                        start_pending_next = 1'b1;
                    end
                end
                rtmf_pkg::OP_END:
                begin
                    if (start_pending_reg)
                    begin
                        start_pending_next = 1'b0;
                        if (window_full)
                        begin
                            fill_next = '0;
                            if (medians_done_reg != rtmf_pkg::COUNT_MAX)
                            begin
                                medians_done_next = medians_done_reg + 16'd1;
                            end
                        end
                        else
                        begin
                            fill_next = fill_reg + IDX_W'(1);
                        end
                    end
                end
                rtmf_pkg::OP_SYNC:
                begin
                    if (sync_hit)
                    begin
                        sync_deadline_next = deadline_sum;
                    end
                end
                rtmf_pkg::OP_SOFT_RESET:
                begin
                    fill_next = '0;
                    medians_done_next = '0;
                    sync_deadline_next = deadline_sum;
                end
                default:
                begin
                    fill_next = fill_reg;
                end
            endcase
        end

        if (cmd.cand_capture)
        begin
            scan_idx_next = '0;
            lt_cnt_next = '0;
            le_cnt_next = '0;
        end

        if (cmd.scan_step && (scan_idx_reg != IDX_LAST))
        begin
            scan_idx_next = scan_idx_reg + IDX_W'(1);
        end

        if (cmp_pend_reg)
        begin
            lt_cnt_next = lt_cnt_reg + CNT_W'(smp_lt);
            le_cnt_next = le_cnt_reg + CNT_W'(smp_le);
        end

        if (cmd.judge && !found && (cand_idx_reg != IDX_LAST))
        begin
            cand_idx_next = cand_idx_reg + IDX_W'(1);
        end

        if (cmd.push)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ignore_left_reg <= '0;
            start_pending_reg <= 1'b0;
            fill_reg <= '0;
            medians_done_reg <= '0;
            sync_deadline_reg <= '0;
            sync_period_reg <= '0;
            sync_medians_reg <= rtmf_pkg::SYNC_MEDIANS_RST;
            out_valid_reg <= 1'b0;
            cand_idx_reg <= '0;
            scan_idx_reg <= '0;
            cmp_pend_reg <= 1'b0;
            lt_cnt_reg <= '0;
            le_cnt_reg <= '0;
        end
        else
        begin
            ignore_left_reg <= ignore_left_next;
            start_pending_reg <= start_pending_next;
            fill_reg <= fill_next;
            medians_done_reg <= medians_done_next;
            sync_deadline_reg <= sync_deadline_next;
            sync_period_reg <= sync_period_next;
            sync_medians_reg <= sync_medians_next;
            out_valid_reg <= out_valid_next;
            cand_idx_reg <= cand_idx_next;
            scan_idx_reg <= scan_idx_next;
            cmp_pend_reg <= cmp_pend_next;
            lt_cnt_reg <= lt_cnt_next;
            le_cnt_reg <= le_cnt_next;
        end
    end

    // The window memory has one write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (cmd.exec && end_taken)
        begin
            window_mem[fill_reg] <= elapsed;
        end
        rd_data_reg <= window_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            in_op_reg <= rtmf_pkg::op_t'(op);
            in_ts_reg <= timestamp;
        end
        if (cmd.exec)
        begin
            if ((in_op_reg == rtmf_pkg::OP_START) && (ignore_left_reg == '0))
            begin
                start_time_reg <= in_ts_reg;
            end
            res_mvalid_reg <= end_taken && window_full;
            res_mtime_reg <= '0;
            res_sync_reg <= (in_op_reg == rtmf_pkg::OP_SYNC) && sync_hit;
        end
        if (cmd.cand_capture)
        begin
            cand_reg <= rd_data_reg;
        end
        if (cmd.judge && found)
        begin
            res_mtime_reg <= cand_reg;
        end
        if (cmd.push)
        begin
            out_mvalid_reg <= res_mvalid_reg;
            out_mtime_reg <= res_mtime_reg;
            out_count_reg <= medians_done_reg;
            out_has_reg <= (medians_done_reg != '0);
            out_sync_reg <= res_sync_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign median_valid = out_mvalid_reg;
    assign median_time = out_mtime_reg;
    assign median_count = out_count_reg;
    assign has_median = out_has_reg;
    assign sync_reached = out_sync_reg;

endmodule

// ===== rtl/core/response_time_median_filter_unit.sv =====
// Top level of the response time median filter: controller plus datapath.
//
//  Channel  Direction  Handshake             Payload
//  in       request    in_valid / in_stall   op, timestamp
//  out      result     out_valid / out_stall median_valid, median_time, median_count,
//                                            has_median, sync_reached
//  cfg      write      cfg_wr_en             cfg_index, cfg_data
//
// A request passes through capture, execute and hand-over to the output register.
// An end request that completes the window adds a median search whose length is set
// by the single read port of the window memory, which is scanned once per candidate
// sample.
// Reset needs no clearing pass; the block can take a request as soon as reset ends.
// While out_stall holds a result, the next request is still taken and executed and
// then waits for the output register.
module response_time_median_filter_unit #(
    parameter int WINDOW = rtmf_pkg::WINDOW_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [rtmf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rtmf_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  logic [rtmf_pkg::OP_W-1:0]         op,
    input  logic [rtmf_pkg::TS_W-1:0]         timestamp,
    output logic                              out_valid,
    input  logic                              out_stall,
    output logic                              median_valid,
    output logic [rtmf_pkg::TS_W-1:0]         median_time,
    output logic [rtmf_pkg::CNT_W16-1:0]      median_count,
    output logic                              has_median,
    output logic                              sync_reached
);

    rtmf_pkg::rtmf_cmd_t    cmd;
    rtmf_pkg::rtmf_status_t status;

    rtmf_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    rtmf_dp #(
        .WINDOW (WINDOW)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .op           (op),
        .timestamp    (timestamp),
        .out_stall    (out_stall),
        .out_valid    (out_valid),
        .median_valid (median_valid),
        .median_time  (median_time),
        .median_count (median_count),
        .has_median   (has_median),
        .sync_reached (sync_reached),
        .cmd          (cmd),
        .status       (status)
    );

endmodule

// ===== rtl/core/rtmf_checker.sv =====
// Port-level assertions for the response time median filter and their bind.
module rtmf_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic                         median_valid,
    input logic [rtmf_pkg::TS_W-1:0]    median_time,
    input logic [rtmf_pkg::CNT_W16-1:0] median_count,
    input logic                         has_median,
    input logic                         sync_reached
);

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled median does not change.
    a_time_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(median_time))
        else $error("median time changed while stalled");

    // The median flag agrees with the reported count.
    a_has_median: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (has_median == (median_count != '0)))
        else $error("has_median disagrees with median_count");

    // A fresh median implies a nonzero count, and no sync report rides with it.
    a_median_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && median_valid |-> has_median && !sync_reached)
        else $error("median result with zero count or sync report");

    // Without a fresh median the reported time is zero.
    a_time_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !median_valid |-> (median_time == '0))
        else $error("median time set without a median");

endmodule

bind response_time_median_filter_unit rtmf_checker u_rtmf_checker (.*);
